/* hdl/ising_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, request and register codes, and the control structs for the
// Ising lattice update block. No dependencies.
package ising_pkg;

    localparam int LATTICE_SIDE_DEF = 32;

    localparam int REQ_W     = 2;
    localparam int SITE_W    = 10;
    localparam int RND_W     = 16;
    localparam int THR_W     = 17;
    localparam int NSUM_W    = 4;
    localparam int MAG_W     = 12;
    localparam int ENERGY_W  = 13;
    localparam int CFG_IDX_W = 2;

    // Fraction bits of the reciprocal used to split a site into row and column.
    localparam int RECIP_SHIFT = 20;

    // Request codes; every other code behaves as a read.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRIAL = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_PAIR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_QUAD = 2'd2;

    localparam logic [THR_W-1:0] THR_PAIR_RST = 17'd11242;
    localparam logic [THR_W-1:0] THR_QUAD_RST = 17'd1929;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic div;
        logic fix;
        logic rd_a;
        logic rd_b;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

/* hdl/ising_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the Ising lattice block: valid/ready plus one request item.
// Depends on ising_pkg.
interface ising_req_if import ising_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [SITE_W-1:0] site;
    logic              spin_value;
    logic [RND_W-1:0]  random;

    modport source (output valid, req_type, site, spin_value, random, input ready);
    modport sink (input valid, req_type, site, spin_value, random, output ready);

endinterface

/* hdl/ising_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel of the Ising lattice block: valid/ready plus one result item.
// Depends on ising_pkg.
interface ising_rsp_if import ising_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       spin_out;
    logic                       flipped;
    logic signed [NSUM_W-1:0]   neighbor_sum;
    logic signed [MAG_W-1:0]    magnetization_sum;
    logic signed [ENERGY_W-1:0] energy_units;

    modport source (output valid, spin_out, flipped, neighbor_sum, magnetization_sum,
                    energy_units, input ready);
    modport sink (input valid, spin_out, flipped, neighbor_sum, magnetization_sum,
                  energy_units, output ready);

endinterface

/* hdl/ising_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the Ising lattice block: clearing pass after reset, then the
// per-item steps. Depends on ising_pkg.
module ising_ctrl import ising_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_FIX   = 7'b0001000,
        S_RD_A  = 7'b0010000,
        S_RD_B  = 7'b0100000,
        S_EXEC  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:  state_next = S_FIX;
            S_FIX:  state_next = S_RD_A;
            S_RD_A: state_next = S_RD_B;
            S_RD_B: state_next = S_EXEC;
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.clear_wr = (state_reg == S_CLEAR);
    assign cmd.capture  = (state_reg == S_IDLE) && in_valid;
    assign cmd.div      = (state_reg == S_DIV);
    assign cmd.fix      = (state_reg == S_FIX);
    assign cmd.rd_a     = (state_reg == S_RD_A);
    assign cmd.rd_b     = (state_reg == S_RD_B);
    // The result is committed only when the output register can take it.
    assign cmd.exec     = (state_reg == S_EXEC) && sts.out_free;

endmodule

/* hdl/ising_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the Ising lattice block: row memory, site decode, Metropolis
// decision, running totals, configuration and output registers. Depends on ising_pkg.
module ising_dpath import ising_pkg::*;
#(
    parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [SITE_W-1:0]          site,
    input  logic                       spin_value,
    input  logic [RND_W-1:0]           random,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [THR_W-1:0]           cfg_data,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output logic                       spin_out,
    output logic                       flipped,
    output logic signed [NSUM_W-1:0]   neighbor_sum,
    output logic signed [MAG_W-1:0]    magnetization_sum,
    output logic signed [ENERGY_W-1:0] energy_units
);

    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
    localparam int ROW_W      = $clog2(LATTICE_SIDE);
    localparam int RECIP      = (1 << RECIP_SHIFT) / LATTICE_SIDE;
    localparam int PROD_W     = SITE_W + RECIP_SHIFT;
    localparam logic [ROW_W-1:0]          LAST_IDX   = ROW_W'(LATTICE_SIDE - 1);
    localparam logic [SITE_W:0]           SIDE_W     = (SITE_W + 1)'(LATTICE_SIDE);
    localparam logic [MAG_W-1:0]          MAG_RST    = MAG_W'(SITE_COUNT);
    localparam logic [ENERGY_W-1:0]       ENERGY_RST = ENERGY_W'(-2 * SITE_COUNT);
    localparam logic                      MAG_LSB    = 1'(SITE_COUNT % 2);

    // Configuration.
    logic             cneg_reg;
    logic [THR_W-1:0] thr_pair_reg;
    logic [THR_W-1:0] thr_quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cneg_reg     <= 1'b0;
            thr_pair_reg <= THR_PAIR_RST;
            thr_quad_reg <= THR_QUAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COUPLING: cneg_reg     <= cfg_data[0];
                CFG_THR_PAIR: thr_pair_reg <= cfg_data;
                CFG_THR_QUAD: thr_quad_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Captured item.
    logic [REQ_W-1:0]  type_reg;
    logic [SITE_W-1:0] site_reg;
    logic              wval_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic              in_range_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg     <= req_type;
            site_reg     <= site;
            wval_reg     <= spin_value;
            rnd_reg      <= random;
            in_range_reg <= (int'(site) < SITE_COUNT);
        end
    end

    // Row and column: a reciprocal multiply gives the row or one less, and a
    // single compare-and-subtract corrects it.
    logic [PROD_W-1:0] prod;
    logic [SITE_W-1:0] q_reg;
    logic [SITE_W:0]   qside;
    logic [SITE_W:0]   rem;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  col_reg;

    assign prod  = PROD_W'(site_reg) * PROD_W'(RECIP);
    assign qside = (SITE_W + 1)'(q_reg) * SIDE_W;
    assign rem   = {1'b0, site_reg} - qside;

    always_ff @(posedge clk)
    begin
        if (cmd.div)
        begin
            q_reg <= prod[PROD_W-1:RECIP_SHIFT];
        end
        if (cmd.fix)
        begin
            if (rem >= SIDE_W)
            begin
                row_reg <= ROW_W'(q_reg + 1'b1);
                col_reg <= ROW_W'(rem - SIDE_W);
            end
            else
            begin
                row_reg <= ROW_W'(q_reg);
                col_reg <= ROW_W'(rem);
            end
        end
    end

    // Torus neighbors.
    logic [ROW_W-1:0] row_up;
    logic [ROW_W-1:0] row_dn;
    logic [ROW_W-1:0] col_rt;
    logic [ROW_W-1:0] col_lf;

    assign row_up = (row_reg == '0) ? LAST_IDX : row_reg - 1'b1;
    assign row_dn = (row_reg == LAST_IDX) ? '0 : row_reg + 1'b1;
    assign col_lf = (col_reg == '0) ? LAST_IDX : col_reg - 1'b1;
    assign col_rt = (col_reg == LAST_IDX) ? '0 : col_reg + 1'b1;

    // Lattice memory, one row per entry; the clearing pass sets every spin to +1.
    logic [LATTICE_SIDE-1:0] lattice_mem [LATTICE_SIDE];
    logic [LATTICE_SIDE-1:0] rd_a_reg;
    logic [LATTICE_SIDE-1:0] rd_b_reg;
    logic [LATTICE_SIDE-1:0] up_row_reg;
    logic [LATTICE_SIDE-1:0] new_row;
    logic                    mem_we;
    logic [ROW_W-1:0]        mem_waddr;
    logic [LATTICE_SIDE-1:0] mem_wdata;
    logic [ROW_W-1:0]        clear_row_reg;
    logic                    change;

    assign mem_we    = cmd.clear_wr || (cmd.exec && change);
    assign mem_waddr = cmd.clear_wr ? clear_row_reg : row_reg;
    assign mem_wdata = cmd.clear_wr ? '1 : new_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_a)
        begin
            rd_a_reg <= lattice_mem[row_up];
            rd_b_reg <= lattice_mem[row_reg];
        end
        else if (cmd.rd_b)
        begin
            rd_a_reg   <= lattice_mem[row_dn];
            up_row_reg <= rd_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_row_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clear_row_reg <= clear_row_reg + 1'b1;
        end
    end

    // Metropolis step. After the reads, rd_b holds the site's row and rd_a the row below.
    logic                       s_c;
    logic                       s_u;
    logic                       s_d;
    logic                       s_r;
    logic                       s_l;
    logic [2:0]                 ones;
    logic signed [NSUM_W-1:0]   nsum;
    logic signed [ENERGY_W-1:0] nsum_x2;
    logic                       nsum_pos;
    logic                       nsum_neg;
    logic                       big_rise;
    logic                       rise_pos;
    logic                       rnd_ok;
    logic                       accept;
    logic                       is_write;
    logic                       is_trial;
    logic                       new_spin;
    logic signed [MAG_W-1:0]    mag_reg;
    logic signed [MAG_W-1:0]    mag_next;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [ENERGY_W-1:0] energy_next;

    assign s_c = rd_b_reg[col_reg];
    assign s_r = rd_b_reg[col_rt];
    assign s_l = rd_b_reg[col_lf];
    assign s_u = up_row_reg[col_reg];
    assign s_d = rd_a_reg[col_reg];

    assign ones    = 3'(s_u) + 3'(s_d) + 3'(s_r) + 3'(s_l);
    assign nsum    = $signed({ones, 1'b0}) - 4'sd4;
    assign nsum_x2 = $signed({{(ENERGY_W - NSUM_W - 1){nsum[NSUM_W-1]}}, nsum, 1'b0});

    assign nsum_pos = (ones > 3'd2);
    assign nsum_neg = (ones < 3'd2);
    assign big_rise = (ones == 3'd0) || (ones == 3'd4);
    // The energy rises when the spin is aligned with its neighbors' field,
    // and the sign is reversed for an antiferromagnetic coupling.
    assign rise_pos = (nsum_pos || nsum_neg) &&
                      (((nsum_pos && s_c) || (nsum_neg && !s_c)) ^ cneg_reg);
    assign rnd_ok   = big_rise ? ({1'b0, rnd_reg} < thr_quad_reg)
                               : ({1'b0, rnd_reg} < thr_pair_reg);
    assign accept   = !rise_pos || rnd_ok;

    assign is_write = (type_reg == REQ_WRITE);
    assign is_trial = (type_reg == REQ_TRIAL);
    assign new_spin = is_write ? wval_reg : !s_c;
    assign change   = in_range_reg &&
                      ((is_write && (wval_reg != s_c)) || (is_trial && accept));

    always_comb
    begin
        new_row          = rd_b_reg;
        new_row[col_reg] = new_spin;
    end

    always_comb
    begin
        mag_next    = mag_reg;
        energy_next = energy_reg;
        if (change)
        begin
            if (new_spin)
            begin
                mag_next    = mag_reg + 12'sd2;
                energy_next = energy_reg - nsum_x2;
            end
            else
            begin
                mag_next    = mag_reg - 12'sd2;
                energy_next = energy_reg + nsum_x2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg    <= MAG_RST;
            energy_reg <= ENERGY_RST;
        end
        else if (cmd.exec)
        begin
            mag_reg    <= mag_next;
            energy_reg <= energy_next;
        end
    end

    // Output register.
    logic                       rsp_valid_reg;
    logic                       spin_out_reg;
    logic                       flipped_reg;
    logic signed [NSUM_W-1:0]   nsum_out_reg;
    logic signed [MAG_W-1:0]    mag_out_reg;
    logic signed [ENERGY_W-1:0] energy_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            spin_out_reg   <= in_range_reg && (change ? new_spin : s_c);
            flipped_reg    <= in_range_reg && is_trial && accept;
            nsum_out_reg   <= in_range_reg ? nsum : '0;
            mag_out_reg    <= mag_next;
            energy_out_reg <= energy_next;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign spin_out          = spin_out_reg;
    assign flipped           = flipped_reg;
    assign neighbor_sum      = nsum_out_reg;
    assign magnetization_sum = mag_out_reg;
    assign energy_units      = energy_out_reg;

    assign sts.clear_last = (clear_row_reg == LAST_IDX);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!rsp_valid_reg || rsp_ready))
        else $error("result committed while the output register was full");

    a_mag_parity: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg[0] == MAG_LSB)
        else $error("spin total changed by an odd amount");

    a_energy_even: assert property (@(posedge clk) disable iff (!rst_n)
        energy_reg[0] == 1'b0)
        else $error("bond total changed by an odd amount");

    a_flip_changes_spin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && in_range_reg && is_trial && accept |=> spin_out_reg != $past(s_c))
        else $error("flipped trial reported an unchanged spin");

endmodule

/* hdl/ising_metropolis_update.sv */
`timescale 1ns / 1ps
// Top level of the 2D Ising lattice block with Metropolis updates.
// Depends on ising_pkg, ising_req_if, ising_rsp_if, ising_ctrl and ising_dpath.
//
// Usage: each request item on req writes a spin, makes one Metropolis trial
// or reads a site; every request gives exactly one result item on rsp with the
// spin, flip flag, neighbor sum and the running magnetization and energy totals.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is
// idle: index 0 coupling sign, 1 threshold for a 4J rise, 2 threshold for 8J.
// Steps: an accepted item passes through the row/column split (one multiply,
// one correction), two reads of the two-port row memory and one execute step
// that writes a changed row back and loads the result into the output register.
// A new item is accepted only after the previous one has left the execute step.
// Reset: after rst_n is released, a clearing pass writes one row per cycle
// through all LATTICE_SIDE rows, setting every spin to +1; req.ready stays low
// during it. Configuration registers return to their defaults at once.
// Stall: a result waits in the output register; the next item is accepted
// meanwhile, and its execute cycle waits until rsp.ready frees the register.
module ising_metropolis_update import ising_pkg::*;
#(
    parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ising_req_if.sink            req,
    ising_rsp_if.source          rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    cmd_t cmd;
    sts_t sts;

    ising_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ising_dpath #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_type          (req.req_type),
        .site              (req.site),
        .spin_value        (req.spin_value),
        .random            (req.random),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .spin_out          (rsp.spin_out),
        .flipped           (rsp.flipped),
        .neighbor_sum      (rsp.neighbor_sum),
        .magnetization_sum (rsp.magnetization_sum),
        .energy_units      (rsp.energy_units)
    );

endmodule
